/* rtl/thrm_pkg.sv */
// ----------------------------------------------------------------------------
// thrm_pkg
// Shared types and constants of the touch health recovery monitor.
// ----------------------------------------------------------------------------
package thrm_pkg;

  localparam int unsigned TimeBitsDefault = 32;
  localparam int unsigned LimitBits       = 16;
  localparam int unsigned StampBits       = 32;
  localparam int unsigned CountBits       = 32;
  localparam int unsigned CoordBits       = 16;
  localparam int unsigned PointBits       = 3;
  localparam int unsigned CfgIdxBits      = 2;

  localparam logic [LimitBits-1:0] FailLimitReset  = 16'd1500;
  localparam logic [LimitBits-1:0] CooldownReset   = 16'd3000;
  localparam logic [LimitBits-1:0] StuckLimitReset = 16'd4000;

  // register indexes of the configuration port
  localparam logic [CfgIdxBits-1:0] RegFailLimit  = 2'd0;
  localparam logic [CfgIdxBits-1:0] RegCooldown   = 2'd1;
  localparam logic [CfgIdxBits-1:0] RegStuckLimit = 2'd2;

  typedef enum logic [1:0] {
    CauseNone  = 2'd0,
    CauseFail  = 2'd1,
    CauseStuck = 2'd2
  } cause_e;

  typedef struct packed {
    logic [LimitBits-1:0] fail_limit;
    logic [LimitBits-1:0] cooldown;
    logic [LimitBits-1:0] stuck_limit;
  } cfg_t;

  typedef struct packed {
    logic                 read_ok;
    logic [PointBits-1:0] point_count;
    logic [CoordBits-1:0] touch_x;
    logic [CoordBits-1:0] touch_y;
    logic [StampBits-1:0] now_ms;
  } poll_t;

  typedef struct packed {
    logic                 recover;
    cause_e               cause;
    logic [CountBits-1:0] recoveries;
    logic                 status_ok;
  } res_t;

endpackage

/* rtl/thrm_cfg.sv */
// ----------------------------------------------------------------------------
// thrm_cfg
// Configuration register file: fail limit, cooldown and stuck limit.
// ----------------------------------------------------------------------------
module thrm_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                wr_en_i,
  input  logic [thrm_pkg::CfgIdxBits-1:0]     wr_idx_i,
  input  logic [thrm_pkg::LimitBits-1:0]      wr_data_i,
  output thrm_pkg::cfg_t                      cfg_o
);
  import thrm_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_idx_i)
        RegFailLimit:  cfg_d.fail_limit  = wr_data_i;
        RegCooldown:   cfg_d.cooldown    = wr_data_i;
        RegStuckLimit: cfg_d.stuck_limit = wr_data_i;
        default:       cfg_d = cfg_q;  // unused index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fail_limit  <= FailLimitReset;
      cfg_q.cooldown    <= CooldownReset;
      cfg_q.stuck_limit <= StuckLimitReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/thrm_core.sv */
// ----------------------------------------------------------------------------
// thrm_core
// Health state and per-poll decision: failure timer, held-press tracker,
// cooldown and recovery count.
// ----------------------------------------------------------------------------
module thrm_core #(
  parameter int unsigned TimeBits = thrm_pkg::TimeBitsDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  thrm_pkg::poll_t poll_i,
  input  thrm_pkg::cfg_t  cfg_i,
  output thrm_pkg::res_t  res_o
);
  import thrm_pkg::*;

  logic                 failing_q, failing_d;
  logic [TimeBits-1:0]  fail_start_q, fail_start_d;
  logic [TimeBits-1:0]  last_rec_q, last_rec_d;
  logic [CountBits-1:0] total_q, total_d;
  logic                 held_q, held_d;
  logic [TimeBits-1:0]  held_since_q, held_since_d;
  logic [CoordBits-1:0] held_x_q, held_x_d;
  logic [CoordBits-1:0] held_y_q, held_y_d;

  // stamp and limits brought to the time width
  logic [TimeBits+StampBits-1:0] now_wide;
  logic [TimeBits+LimitBits-1:0] fail_lim_wide, cool_wide, stuck_lim_wide;
  logic [TimeBits-1:0]           now_t, fail_lim_t, cool_t, stuck_lim_t;

  assign now_wide       = {{TimeBits{1'b0}}, poll_i.now_ms};
  assign fail_lim_wide  = {{TimeBits{1'b0}}, cfg_i.fail_limit};
  assign cool_wide      = {{TimeBits{1'b0}}, cfg_i.cooldown};
  assign stuck_lim_wide = {{TimeBits{1'b0}}, cfg_i.stuck_limit};
  assign now_t          = now_wide[TimeBits-1:0];
  assign fail_lim_t     = fail_lim_wide[TimeBits-1:0];
  assign cool_t         = cool_wide[TimeBits-1:0];
  assign stuck_lim_t    = stuck_lim_wide[TimeBits-1:0];

  logic [TimeBits-1:0] fail_age, cool_age, held_age;
  logic                fail_due, cool_done, stuck_due, moved;
  cause_e              cause;

  assign fail_age  = now_t - fail_start_q;
  assign cool_age  = now_t - last_rec_q;
  assign held_age  = now_t - held_since_q;
  assign fail_due  = fail_age >= fail_lim_t;
  assign cool_done = cool_age >= cool_t;
  assign stuck_due = held_age >= stuck_lim_t;
  assign moved     = !held_q || (poll_i.touch_x != held_x_q) || (poll_i.touch_y != held_y_q);

  always_comb begin
    failing_d    = failing_q;
    fail_start_d = fail_start_q;
    last_rec_d   = last_rec_q;
    held_d       = held_q;
    held_since_d = held_since_q;
    held_x_d     = held_x_q;
    held_y_d     = held_y_q;
    cause        = CauseNone;
    if (!poll_i.read_ok) begin
      if (!failing_q) begin
        failing_d    = 1'b1;
        fail_start_d = now_t;
      end else if (fail_due && cool_done) begin
        cause        = CauseFail;
        last_rec_d   = now_t;
        fail_start_d = now_t;
      end
    end else begin
      failing_d = 1'b0;
      if (poll_i.point_count == '0) begin
        held_d = 1'b0;
      end else if (moved) begin
        // new or moved press restarts the tracker
        held_d       = 1'b1;
        held_since_d = now_t;
        held_x_d     = poll_i.touch_x;
        held_y_d     = poll_i.touch_y;
      end else if (stuck_due && cool_done) begin
        cause      = CauseStuck;
        last_rec_d = now_t;
        held_d     = 1'b0;
      end
    end
    total_d = total_q + {{(CountBits-1){1'b0}}, (cause != CauseNone)};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      failing_q    <= 1'b0;
      fail_start_q <= '0;
      last_rec_q   <= '0;
      total_q      <= '0;
      held_q       <= 1'b0;
      held_since_q <= '0;
      held_x_q     <= '0;
      held_y_q     <= '0;
    end else if (step_i) begin
      failing_q    <= failing_d;
      fail_start_q <= fail_start_d;
      last_rec_q   <= last_rec_d;
      total_q      <= total_d;
      held_q       <= held_d;
      held_since_q <= held_since_d;
      held_x_q     <= held_x_d;
      held_y_q     <= held_y_d;
    end
  end

  assign res_o.recover    = (cause != CauseNone);
  assign res_o.cause      = cause;
  assign res_o.recoveries = total_d;
  assign res_o.status_ok  = poll_i.read_ok;

  // a stuck-press recovery drops the tracker
  a_stuck_clears_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && cause == CauseStuck) |=> !held_q)
    else $error("held flag survived a stuck-press recovery");

  // the count moves by exactly one on each recovery
  a_total_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && cause != CauseNone) |=> (total_q == $past(total_q) + 1'b1))
    else $error("recovery count did not advance");

  // a failed read leaves the held-press tracker alone
  a_fail_keeps_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && !poll_i.read_ok) |=> ($stable(held_q) && $stable(held_since_q)
                                     && $stable(held_x_q) && $stable(held_y_q)))
    else $error("failed read disturbed the held-press tracker");

endmodule

/* rtl/touch_health_recovery_monitor.sv */
// ----------------------------------------------------------------------------
// touch_health_recovery_monitor
// Watches touch-controller polls and requests a controller recovery on
// persistent read failure or on a stuck press, with a cooldown in between.
// ----------------------------------------------------------------------------
// Each poll word gives exactly one result word. The block takes one poll per
// cycle while in_ready_o is high, its result registered: the poll lands in
// an input register, the decision logic (three modular subtractions and
// compares against the limits) runs against the health state and updates it
// in that same cycle, and the result is held in an output register until
// taken. The health state is updated once per poll, so a poll always sees
// the state left by the poll before it, even back to back. While a result
// sits unread, one more poll can wait in the input register; in_ready_o
// drops only when both are full. Configuration writes are taken every cycle
// and should only be issued while no poll is in flight. TIME_BITS sets the
// width of the stored timestamps and the modulus of all time differences.
module touch_health_recovery_monitor #(
  parameter int unsigned TIME_BITS = thrm_pkg::TimeBitsDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // poll words
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              read_ok_i,
  input  logic [thrm_pkg::PointBits-1:0]    point_count_i,
  input  logic [thrm_pkg::CoordBits-1:0]    touch_x_i,
  input  logic [thrm_pkg::CoordBits-1:0]    touch_y_i,
  input  logic [thrm_pkg::StampBits-1:0]    now_ms_i,
  // result words
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              recover_o,
  output logic [1:0]                        cause_o,
  output logic [thrm_pkg::CountBits-1:0]    recoveries_o,
  output logic                              status_ok_o,
  // configuration writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [thrm_pkg::CfgIdxBits-1:0]   cfg_index_i,
  input  logic [thrm_pkg::LimitBits-1:0]    cfg_data_i
);
  import thrm_pkg::*;

  cfg_t  cfg;
  poll_t poll_q;
  logic  poll_valid_q;
  res_t  res, res_q;
  logic  res_valid_q;
  logic  advance, step;

  // config registers are always writable
  assign cfg_ready_o = 1'b1;

  thrm_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i),
    .wr_idx_i  (cfg_index_i),
    .wr_data_i (cfg_data_i),
    .cfg_o     (cfg)
  );

  // result register frees up when empty or being taken
  assign advance    = !res_valid_q || out_ready_i;
  // poll in the input register is decided when the result register can load
  assign step       = poll_valid_q && advance;
  assign in_ready_o = !poll_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poll_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      poll_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      poll_q.read_ok     <= read_ok_i;
      poll_q.point_count <= point_count_i;
      poll_q.touch_x     <= touch_x_i;
      poll_q.touch_y     <= touch_y_i;
      poll_q.now_ms      <= now_ms_i;
    end
  end

  // decision logic and health state
  thrm_core #(
    .TimeBits (TIME_BITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .poll_i (poll_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= poll_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign out_valid_o  = res_valid_q;
  assign recover_o    = res_q.recover;
  assign cause_o      = res_q.cause;
  assign recoveries_o = res_q.recoveries;
  assign status_ok_o  = res_q.status_ok;

endmodule
